FILE: hdl/fcs_pkg.sv
`default_nettype none
package fcs_pkg;

	localparam int MAX_BOIDS_DEF    = 64;
	localparam int FIELD_WIDTH_DEF  = 1024;
	localparam int FIELD_HEIGHT_DEF = 1024;

	localparam int POS_W   = 18;
	localparam int DIR_W   = 32;
	localparam int DT_W    = 16;
	localparam int IDX_W   = 6;
	localparam int AVOID_W = 10;
	localparam int KIND_W  = 2;
	localparam int FRAC_W  = 8;

	localparam logic [AVOID_W-1:0] AVOID_RESET = 10'd5;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD  = 2'd0,
		KIND_STEP  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_WAIT,
		ST_DIV_INIT,
		ST_DIV,
		ST_SELF,
		ST_SELF_LAT,
		ST_NBR,
		ST_DRAIN,
		ST_UPD,
		ST_MUL,
		ST_DISP,
		ST_WB
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic sum_rd;
		logic nbr_rd;
		logic nbr_use;
		logic start_step;
		logic div_init;
		logic div_step;
		logic self_latch;
		logic upd;
		logic mul;
		logic disp;
		logic emit;
		logic load;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

FILE: hdl/fcs_if.sv
`default_nettype none
interface fcs_in_if import fcs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [KIND_W-1:0]       kind;
	logic [POS_W-1:0]        load_x;
	logic [POS_W-1:0]        load_y;
	logic signed [DIR_W-1:0] load_dir_x;
	logic signed [DIR_W-1:0] load_dir_y;
	logic [DT_W-1:0]         time_step;

	modport source (output valid, kind, load_x, load_y, load_dir_x, load_dir_y, time_step,
		input ready);
	modport sink (input valid, kind, load_x, load_y, load_dir_x, load_dir_y, time_step,
		output ready);
endinterface

interface fcs_out_if import fcs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        boid_index;
	logic [POS_W-1:0]        new_x;
	logic [POS_W-1:0]        new_y;
	logic signed [DIR_W-1:0] new_dir_x;
	logic signed [DIR_W-1:0] new_dir_y;
	logic                    last_boid;

	modport source (output valid, boid_index, new_x, new_y, new_dir_x, new_dir_y, last_boid,
		input ready);
	modport sink (input valid, boid_index, new_x, new_y, new_dir_x, new_dir_y, last_boid,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/fcs_ram.sv
`default_nettype none
module fcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: hdl/fcs_ctrl.sv
`default_nettype none
module fcs_ctrl import fcs_pkg::*; #(
	parameter int MAX_BOIDS = MAX_BOIDS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [KIND_W-1:0]                in_kind,
	input  wire status_t                          status,
	output cmd_t                                  cmd,
	output logic [$clog2(MAX_BOIDS)-1:0]          rd_addr,
	output logic [$clog2(MAX_BOIDS)-1:0]          wr_addr,
	output logic [$clog2(MAX_BOIDS+1)-1:0]        count
);
	localparam int AW    = $clog2(MAX_BOIDS);
	localparam int CW    = $clog2(MAX_BOIDS + 1);
	localparam int SUM_W = POS_W + AW;
	localparam int SW    = $clog2(SUM_W + 1);
	localparam logic [SW-1:0] DRAIN_LAST = SW'(2);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] i_q, i_d;
	logic [CW-1:0] j_q, j_d;
	logic [SW-1:0] step_q, step_d;
	logic          j_last;
	logic          i_last;

	assign count  = cnt_q;
	assign j_last = (CW'(j_q + 1'b1) == cnt_q);
	assign i_last = (CW'(CW'(i_q) + 1'b1) == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		i_d      = i_q;
		j_d      = j_q;
		step_d   = step_q;
		cmd      = '0;
		rd_addr  = j_q[AW-1:0];
		wr_addr  = i_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_kind)
						KIND_LOAD: begin
							if (cnt_q < CW'(MAX_BOIDS)) begin
								cmd.load = 1'b1;
								wr_addr  = cnt_q[AW-1:0];
								cnt_d    = CW'(cnt_q + 1'b1);
							end
						end
						KIND_CLEAR: cnt_d = '0;
						KIND_STEP: begin
							if (cnt_q != '0) begin
								cmd.start_step = 1'b1;
								i_d     = '0;
								j_d     = '0;
								state_d = ST_SUM;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SUM: begin
				cmd.rd_en  = 1'b1;
				cmd.sum_rd = 1'b1;
				j_d        = CW'(j_q + 1'b1);
				if (j_last) begin
					j_d     = '0;
					state_d = ST_SUM_WAIT;
				end
			end
			ST_SUM_WAIT: state_d = ST_DIV_INIT;
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				step_d       = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = SW'(step_q + 1'b1);
				if (step_q == SW'(SUM_W - 1)) begin
					state_d = ST_SELF;
				end
			end
			ST_SELF: begin
				cmd.rd_en = 1'b1;
				rd_addr   = i_q;
				state_d   = ST_SELF_LAT;
			end
			ST_SELF_LAT: begin
				cmd.self_latch = 1'b1;
				j_d            = '0;
				state_d        = ST_NBR;
			end
			ST_NBR: begin
				cmd.rd_en   = 1'b1;
				cmd.nbr_rd  = 1'b1;
				cmd.nbr_use = (j_q != CW'(i_q));
				j_d         = CW'(j_q + 1'b1);
				if (j_last) begin
					j_d     = '0;
					step_d  = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// let the distance pipeline settle into the avoidance sum
				step_d = SW'(step_q + 1'b1);
				if (step_q == DRAIN_LAST) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				cmd.disp = 1'b1;
				state_d  = ST_WB;
			end
			ST_WB: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = i_last;
					if (i_last) begin
						state_d = ST_IDLE;
					end else begin
						i_d     = AW'(i_q + 1'b1);
						state_d = ST_SELF;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_BOIDS))
		else $error("boid count beyond table depth");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result written over a pending transaction");
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cnt_q == CW'($past(cnt_q) + 1'b1))
		else $error("load did not advance the count");
	a_step_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (CW'(i_q) < cnt_q))
		else $error("boid index outside the table during a step");
`endif
endmodule
`default_nettype wire

FILE: hdl/fcs_dpath.sv
`default_nettype none
module fcs_dpath import fcs_pkg::*; #(
	parameter int MAX_BOIDS    = MAX_BOIDS_DEF,
	parameter int FIELD_WIDTH  = FIELD_WIDTH_DEF,
	parameter int FIELD_HEIGHT = FIELD_HEIGHT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cmd_t                             cmd,
	output status_t                               status,
	input  wire logic [$clog2(MAX_BOIDS)-1:0]     rd_addr,
	input  wire logic [$clog2(MAX_BOIDS)-1:0]     wr_addr,
	input  wire logic [$clog2(MAX_BOIDS+1)-1:0]   count,
	input  wire logic                             cfg_wr_en,
	input  wire logic [AVOID_W-1:0]               cfg_wr_data,
	input  wire logic [POS_W-1:0]                 load_x,
	input  wire logic [POS_W-1:0]                 load_y,
	input  wire logic signed [DIR_W-1:0]          load_dir_x,
	input  wire logic signed [DIR_W-1:0]          load_dir_y,
	input  wire logic [DT_W-1:0]                  time_step,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [IDX_W-1:0]                      boid_index,
	output logic [POS_W-1:0]                      new_x,
	output logic [POS_W-1:0]                      new_y,
	output logic signed [DIR_W-1:0]               new_dir_x,
	output logic signed [DIR_W-1:0]               new_dir_y,
	output logic                                  last_boid
);
	localparam int AW      = $clog2(MAX_BOIDS);
	localparam int CW      = $clog2(MAX_BOIDS + 1);
	localparam int SUM_W   = POS_W + AW;
	localparam int OFF_W   = POS_W + 1;
	localparam int SQ_W    = 2 * OFF_W;
	localparam int THR_W   = 2 * (AVOID_W + FRAC_W);
	localparam int AX_W    = OFF_W + AW;
	localparam int S_W     = ((AX_W > DIR_W) ? AX_W : DIR_W) + 2;
	localparam int PROD_W  = DIR_W + DT_W + 1;
	localparam int RND_W   = PROD_W + 1;
	localparam int DISP_W  = RND_W - 16;
	localparam int NP_W    = DISP_W + 1;
	localparam logic signed [NP_W:0] SPAN_X = (NP_W+1)'(FIELD_WIDTH * 256);
	localparam logic signed [NP_W:0] SPAN_Y = (NP_W+1)'(FIELD_HEIGHT * 256);
	localparam logic signed [S_W-1:0] SAT_HI =
		{{(S_W-DIR_W+1){1'b0}}, {(DIR_W-1){1'b1}}};
	localparam logic signed [S_W-1:0] SAT_LO =
		{{(S_W-DIR_W+1){1'b1}}, {(DIR_W-1){1'b0}}};

	function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [S_W-1:0] v);
		logic signed [S_W-1:0] r;
		r = v;
		if (v > SAT_HI) r = SAT_HI;
		if (v < SAT_LO) r = SAT_LO;
		return r[DIR_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] wrap_axis(input logic signed [NP_W-1:0] p,
		input logic signed [NP_W:0] span);
		logic signed [NP_W:0] v;
		v = {p[NP_W-1], p};
		if (v < 0) v = v + span;
		if (v >= span) v = v - span;
		if (v < 0) v = '0;
		if (v > span - 1) v = span - 1;
		return v[POS_W-1:0];
	endfunction

	// table memories
	logic [2*POS_W-1:0] pos_wdata, pos_rdata;
	logic [2*DIR_W-1:0] dir_wdata, dir_rdata;
	logic               wr_en;
	logic [POS_W-1:0]   rx, ry;
	logic [POS_W-1:0]   wx, wy;

	logic [AVOID_W-1:0]      avoid_q;
	logic [THR_W-1:0]        thr_sq_q;
	logic [DT_W-1:0]         dt_q;
	logic                    sum_v_q;
	logic [SUM_W-1:0]        sum_x_q, sum_y_q;
	logic [CW-1:0]           rem_x_q, rem_y_q;
	logic [SUM_W-1:0]        quo_x_q, quo_y_q;
	logic [CW:0]             r2_x, r2_y;
	logic                    ge_x, ge_y;
	logic [POS_W-1:0]        px_q, py_q;
	logic signed [DIR_W-1:0] dirx_q, diry_q;
	logic                    nbr_v_q;
	logic signed [OFF_W-1:0] ox_s1, oy_s1, ox_s2, oy_s2;
	logic                    v_s1, v_s2;
	logic signed [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [SQ_W:0]           d2;
	logic signed [AX_W-1:0]  ax_q, ay_q;
	logic signed [OFF_W-1:0] cdx, cdy;
	logic signed [S_W-1:0]   ux, uy;
	logic signed [DIR_W-1:0] dx_q, dy_q;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
	logic [RND_W-1:0]        rnd_x, rnd_y;
	logic [DISP_W-1:0]       disp_x, disp_y;
	logic signed [NP_W-1:0]  np_x_q, np_y_q;
	logic                    out_valid_q;

	assign rx = pos_rdata[POS_W-1:0];
	assign ry = pos_rdata[2*POS_W-1:POS_W];
	assign wx = wrap_axis(np_x_q, SPAN_X);
	assign wy = wrap_axis(np_y_q, SPAN_Y);

	assign wr_en     = cmd.load | cmd.emit;
	assign pos_wdata = cmd.load ? {load_y, load_x} : {wy, wx};
	assign dir_wdata = cmd.load ? {load_dir_y, load_dir_x} : {dy_q, dx_q};

	fcs_ram #(.WIDTH(2*POS_W), .DEPTH(MAX_BOIDS)) u_pos_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (pos_wdata),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (pos_rdata)
	);

	fcs_ram #(.WIDTH(2*DIR_W), .DEPTH(MAX_BOIDS)) u_dir_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (dir_wdata),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (dir_rdata)
	);

	// configuration and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avoid_q <= AVOID_RESET;
		end else if (cfg_wr_en) begin
			avoid_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		thr_sq_q <= {avoid_q, {FRAC_W{1'b0}}} * {avoid_q, {FRAC_W{1'b0}}};
	end

	// centre of mass: accumulate then restoring division by the count
	assign r2_x = {rem_x_q, quo_x_q[SUM_W-1]};
	assign r2_y = {rem_y_q, quo_y_q[SUM_W-1]};
	assign ge_x = (r2_x >= {1'b0, count});
	assign ge_y = (r2_y >= {1'b0, count});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_v_q     <= 1'b0;
			nbr_v_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sum_v_q <= cmd.sum_rd;
			nbr_v_q <= cmd.nbr_rd & cmd.nbr_use;
			v_s1    <= nbr_v_q;
			v_s2    <= v_s1;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_step) begin
			dt_q    <= time_step;
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (sum_v_q) begin
			sum_x_q <= SUM_W'(sum_x_q + SUM_W'(rx));
			sum_y_q <= SUM_W'(sum_y_q + SUM_W'(ry));
		end
		if (cmd.div_init) begin
			rem_x_q <= '0;
			rem_y_q <= '0;
			quo_x_q <= sum_x_q;
			quo_y_q <= sum_y_q;
		end else if (cmd.div_step) begin
			rem_x_q <= ge_x ? CW'(r2_x - {1'b0, count}) : r2_x[CW-1:0];
			rem_y_q <= ge_y ? CW'(r2_y - {1'b0, count}) : r2_y[CW-1:0];
			quo_x_q <= {quo_x_q[SUM_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[SUM_W-2:0], ge_y};
		end
	end

	// neighbour scan: offset, squares, threshold and accumulate
	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (cmd.self_latch) begin
			px_q   <= rx;
			py_q   <= ry;
			dirx_q <= dir_rdata[DIR_W-1:0];
			diry_q <= dir_rdata[2*DIR_W-1:DIR_W];
			ax_q   <= '0;
			ay_q   <= '0;
		end else if (v_s2 && (d2 < (SQ_W+1)'(thr_sq_q))) begin
			ax_q <= ax_q - {{(AX_W-OFF_W){ox_s2[OFF_W-1]}}, ox_s2};
			ay_q <= ay_q - {{(AX_W-OFF_W){oy_s2[OFF_W-1]}}, oy_s2};
		end
		ox_s1  <= {1'b0, rx} - {1'b0, px_q};
		oy_s1  <= {1'b0, ry} - {1'b0, py_q};
		ox_s2  <= ox_s1;
		oy_s2  <= oy_s1;
		sqx_s2 <= ox_s1 * ox_s1;
		sqy_s2 <= oy_s1 * oy_s1;
	end

	// direction update, displacement and new position
	assign cdx = {1'b0, quo_x_q[POS_W-1:0]} - {1'b0, px_q};
	assign cdy = {1'b0, quo_y_q[POS_W-1:0]} - {1'b0, py_q};
	assign ux  = {{(S_W-DIR_W){dirx_q[DIR_W-1]}}, dirx_q}
		+ {{(S_W-OFF_W){cdx[OFF_W-1]}}, cdx}
		+ {{(S_W-AX_W){ax_q[AX_W-1]}}, ax_q};
	assign uy  = {{(S_W-DIR_W){diry_q[DIR_W-1]}}, diry_q}
		+ {{(S_W-OFF_W){cdy[OFF_W-1]}}, cdy}
		+ {{(S_W-AX_W){ay_q[AX_W-1]}}, ay_q};

	assign rnd_x  = {prod_x_q[PROD_W-1], prod_x_q} + RND_W'(32768);
	assign rnd_y  = {prod_y_q[PROD_W-1], prod_y_q} + RND_W'(32768);
	assign disp_x = rnd_x[RND_W-1:16];
	assign disp_y = rnd_y[RND_W-1:16];

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			dx_q <= sat_dir(ux);
			dy_q <= sat_dir(uy);
		end
		if (cmd.mul) begin
			prod_x_q <= dx_q * $signed({1'b0, dt_q});
			prod_y_q <= dy_q * $signed({1'b0, dt_q});
		end
		if (cmd.disp) begin
			np_x_q <= {{(NP_W-POS_W){1'b0}}, px_q} + {disp_x[DISP_W-1], disp_x};
			np_y_q <= {{(NP_W-POS_W){1'b0}}, py_q} + {disp_y[DISP_W-1], disp_y};
		end
		if (cmd.emit) begin
			boid_index <= IDX_W'(wr_addr);
			new_x      <= wx;
			new_y      <= wy;
			new_dir_x  <= dx_q;
			new_dir_y  <= dy_q;
			last_boid  <= cmd.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_init || cmd.div_step) |-> (count != '0))
		else $error("division by an empty table");
	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(nbr_v_q, 2))
		else $error("neighbour pipeline lost step");
	a_emit_set: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted result not presented");
`endif
endmodule
`default_nettype wire

FILE: hdl/flock_cohesion_separation_step.sv
// Channel   | Dir | Handshake     | Payload
// items     | in  | valid/ready   | kind, load_x, load_y, load_dir_x, load_dir_y, time_step
// results   | out | valid/ready   | boid_index, new_x, new_y, new_dir_x, new_dir_y, last_boid
// cfg       | in  | cfg_wr_en     | cfg_wr_data (avoid_distance)
//
// Load and clear transactions complete in the idle state without leaving it.
// A step scans every boid for each boid in turn, through
// the single read port of the position memory during the neighbour scan.
// arst_n clears the boid count, the controller and the output valid; memories are not cleared.
// A stalled results channel holds the step at the write-back of the next boid.
`default_nettype none
module flock_cohesion_separation_step import fcs_pkg::*; #(
	parameter int MAX_BOIDS    = MAX_BOIDS_DEF,
	parameter int FIELD_WIDTH  = FIELD_WIDTH_DEF,
	parameter int FIELD_HEIGHT = FIELD_HEIGHT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	fcs_in_if.sink                  items,
	fcs_out_if.source               results,
	input  wire logic               cfg_wr_en,
	input  wire logic [AVOID_W-1:0] cfg_wr_data
);
	localparam int AW = $clog2(MAX_BOIDS);
	localparam int CW = $clog2(MAX_BOIDS + 1);

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] count;

	fcs_ctrl #(.MAX_BOIDS(MAX_BOIDS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.in_kind  (items.kind),
		.status   (status),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.count    (count)
	);

	fcs_dpath #(
		.MAX_BOIDS    (MAX_BOIDS),
		.FIELD_WIDTH  (FIELD_WIDTH),
		.FIELD_HEIGHT (FIELD_HEIGHT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.count       (count),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.load_x      (items.load_x),
		.load_y      (items.load_y),
		.load_dir_x  (items.load_dir_x),
		.load_dir_y  (items.load_dir_y),
		.time_step   (items.time_step),
		.out_valid   (results.valid),
		.out_ready   (results.ready),
		.boid_index  (results.boid_index),
		.new_x       (results.new_x),
		.new_y       (results.new_y),
		.new_dir_x   (results.new_dir_x),
		.new_dir_y   (results.new_dir_y),
		.last_boid   (results.last_boid)
	);
endmodule
`default_nettype wire
